### rtl/core/muer_pkg.sv
// Shared constants for the multi-sensor ultrasonic echo ranger.
package muer_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned PERIOD_W   = 20;
    localparam int unsigned PULSE_W    = 8;
    localparam int unsigned SCALE_W    = 16;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned ECHO_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_PERIOD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_WIDTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_Q16      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_VALID_MM   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FALLBACK_MM    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PUBLISH_PERIOD = 3'd5;

    // Register values after reset
    localparam logic [PERIOD_W-1:0] RST_TRIGGER_PERIOD = 20'd10000;
    localparam logic [PULSE_W-1:0]  RST_TRIGGER_WIDTH  = 8'd10;
    localparam logic [SCALE_W-1:0]  RST_SCALE_Q16      = 16'd11298;
    localparam logic [DIST_W-1:0]   RST_MAX_VALID_MM   = 16'd2000;
    localparam logic [DIST_W-1:0]   RST_FALLBACK_MM    = 16'd4000;
    localparam logic [PERIOD_W-1:0] RST_PUBLISH_PERIOD = 20'd16500;

endpackage

### rtl/core/multi_ultrasonic_echo_ranger_top.sv
// Multi-sensor ultrasonic ranger: trigger, publish timing and echo width to distance.
//
// One request on the input channel is one microsecond tick carrying the echo
// level of each sensor (bit i is sensor i). Each request yields exactly one
// result: the shared trigger level, the publish flag, a mask of sensors that
// latched a new distance on that tick, and the range-checked distance of each sensor.
// Echo width times the Q16 scale goes through one multiplier per sensor.
//
// The request lands in an input register, and when the result register is free
// the edge computes all state updates and loads the result register. One request
// is taken every cycle while results are taken; throughput is one per cycle.
// When the receiver stalls, the result holds and the input register fills,
// after which o_in_ready drops until the result is taken.
//
// Reset (synchronous, active low) clears counters, echo state and stored
// distances, and loads the default configuration. Configuration writes on
// i_cfg_we take effect at the next edge; unknown indexes are ignored.
module multi_ultrasonic_echo_ranger_top
    import muer_pkg::*;
#(
    parameter int NUM_SENSORS = 3,
    parameter int WIDTH_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ECHO_W-1:0]     i_echo_levels,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_trigger_out,
    output logic                  o_publish_flag,
    output logic [ECHO_W-1:0]     o_new_measure_mask,
    output logic [DIST_W-1:0]     o_distance_a_mm,
    output logic [DIST_W-1:0]     o_distance_b_mm,
    output logic [DIST_W-1:0]     o_distance_c_mm
);

    localparam int SUM_W = (WIDTH_BITS + 17 > 33) ? WIDTH_BITS + 17 : 33;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

    // configuration
    logic [PERIOD_W-1:0] r_trig_period;
    logic [PULSE_W-1:0]  r_trig_width;
    logic [SCALE_W-1:0]  r_scale;
    logic [DIST_W-1:0]   r_max_valid;
    logic [DIST_W-1:0]   r_fallback;
    logic [PERIOD_W-1:0] r_pub_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_period <= RST_TRIGGER_PERIOD;
            r_trig_width  <= RST_TRIGGER_WIDTH;
            r_scale       <= RST_SCALE_Q16;
            r_max_valid   <= RST_MAX_VALID_MM;
            r_fallback    <= RST_FALLBACK_MM;
            r_pub_period  <= RST_PUBLISH_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TRIGGER_PERIOD: r_trig_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_TRIGGER_WIDTH:  r_trig_width  <= i_cfg_data[PULSE_W-1:0];
                CFG_SCALE_Q16:      r_scale       <= i_cfg_data[SCALE_W-1:0];
                CFG_MAX_VALID_MM:   r_max_valid   <= i_cfg_data[DIST_W-1:0];
                CFG_FALLBACK_MM:    r_fallback    <= i_cfg_data[DIST_W-1:0];
                CFG_PUBLISH_PERIOD: r_pub_period  <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: input register, then result register
    logic              r_in_valid;
    logic [ECHO_W-1:0] r_in_levels;
    logic              r_out_valid;
    logic              w_out_free;
    logic              w_in_go;
    logic              w_accept;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_go    = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_in_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_levels <= i_echo_levels;
        end
    end

    // trigger and publish timing
    logic [PERIOD_W-1:0] r_period_cnt;
    logic [PULSE_W-1:0]  r_pulse_cnt;
    logic [PERIOD_W-1:0] r_pub_cnt;
    logic [PERIOD_W-1:0] n_period_cnt;
    logic [PULSE_W-1:0]  n_pulse_cnt;
    logic [PERIOD_W-1:0] n_pub_cnt;
    logic [PERIOD_W:0]   w_period_inc;
    logic [PERIOD_W:0]   w_pub_inc;
    logic [PULSE_W-1:0]  w_pulse;
    logic                w_trig;
    logic                w_pub;

    always_comb begin
        w_period_inc = {1'b0, r_period_cnt} + (PERIOD_W + 1)'(1);
        if (w_period_inc >= {1'b0, r_trig_period}) begin
            n_period_cnt = '0;
            w_pulse      = r_trig_width;
        end else begin
            n_period_cnt = w_period_inc[PERIOD_W-1:0];
            w_pulse      = r_pulse_cnt;
        end
        w_trig      = (w_pulse != '0);
        n_pulse_cnt = w_trig ? w_pulse - PULSE_W'(1) : '0;

        w_pub_inc = {1'b0, r_pub_cnt} + (PERIOD_W + 1)'(1);
        w_pub     = (w_pub_inc >= {1'b0, r_pub_period});
        n_pub_cnt = w_pub ? '0 : w_pub_inc[PERIOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_cnt <= '0;
            r_pulse_cnt  <= '0;
            r_pub_cnt    <= '0;
        end else if (w_in_go) begin
            r_period_cnt <= n_period_cnt;
            r_pulse_cnt  <= n_pulse_cnt;
            r_pub_cnt    <= n_pub_cnt;
        end
    end

    // per-sensor echo lanes
    logic [DIST_W-1:0]      w_dist [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] w_mask;

    genvar g;
    generate
        for (g = 0; g < NUM_SENSORS; g++) begin : g_lane
            logic                  r_last;
            logic [WIDTH_BITS-1:0] r_width;
            logic [DIST_W-1:0]     r_stored;
            logic [WIDTH_BITS-1:0] n_width;
            logic [DIST_W-1:0]     n_stored;
            logic                  w_cur;
            logic [SUM_W-1:0]      w_sum;
            logic [DIST_W-1:0]     w_round;
            logic                  w_lane_mask;
            logic [DIST_W-1:0]     w_lane_dist;

            if (g < ECHO_W) begin : g_wired
                assign w_cur = r_in_levels[g];
            end else begin : g_absent
                assign w_cur = 1'b0;
            end

            always_comb begin
                w_sum   = SUM_W'(r_width) * SUM_W'(r_scale) + SUM_W'(32768);
                w_round = (w_sum[SUM_W-1:32] != '0) ? {DIST_W{1'b1}} : w_sum[31:16];
                n_width  = r_width;
                n_stored = r_stored;
                w_lane_mask = 1'b0;
                if (w_cur && !r_last) begin
                    n_width = '0;
                end else if (w_cur) begin
                    if (r_width != WIDTH_MAX) begin
                        n_width = r_width + WIDTH_BITS'(1);
                    end
                end else if (r_last) begin
                    n_stored    = w_round;
                    w_lane_mask = 1'b1;
                end
                // zero or out of range reads back as the fallback
                if (n_stored == '0 || n_stored >= r_max_valid) begin
                    w_lane_dist = r_fallback;
                end else begin
                    w_lane_dist = n_stored;
                end
            end

            assign w_mask[g] = w_lane_mask;
            assign w_dist[g] = w_lane_dist;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_last   <= 1'b0;
                    r_width  <= '0;
                    r_stored <= '0;
                end else if (w_in_go) begin
                    r_last   <= w_cur;
                    r_width  <= n_width;
                    r_stored <= n_stored;
                end
            end
        end
    endgenerate

    // result register
    logic              r_out_trig;
    logic              r_out_pub;
    logic [ECHO_W-1:0] r_out_mask;
    logic [DIST_W-1:0] r_out_dist [ECHO_W];
    logic [ECHO_W-1:0] w_out_mask;
    logic [DIST_W-1:0] w_out_dist [ECHO_W];

    genvar k;
    generate
        for (k = 0; k < ECHO_W; k++) begin : g_out
            if (k < NUM_SENSORS) begin : g_present
                assign w_out_mask[k] = w_mask[k];
                assign w_out_dist[k] = w_dist[k];
            end else begin : g_missing
                assign w_out_mask[k] = 1'b0;
                assign w_out_dist[k] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_go) begin
            r_out_trig <= w_trig;
            r_out_pub  <= w_pub;
            r_out_mask <= w_out_mask;
            r_out_dist <= w_out_dist;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_trigger_out      = r_out_trig;
    assign o_publish_flag     = r_out_pub;
    assign o_new_measure_mask = r_out_mask;
    assign o_distance_a_mm    = r_out_dist[0];
    assign o_distance_b_mm    = r_out_dist[1];
    assign o_distance_c_mm    = r_out_dist[2];

endmodule

### rtl/core/muer_check.sv
// Port-level checks for the echo ranger, bound to the top level.
module muer_check
    import muer_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_trigger_out,
    input logic                  o_publish_flag,
    input logic [ECHO_W-1:0]     o_new_measure_mask,
    input logic [DIST_W-1:0]     o_distance_a_mm,
    input logic [DIST_W-1:0]     o_distance_b_mm,
    input logic [DIST_W-1:0]     o_distance_c_mm
);

    // input side stalls only behind a stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    // a result leaves only by being taken
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("result dropped before it was taken");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_trigger_out)
            && $stable(o_publish_flag) && $stable(o_new_measure_mask)
            && $stable(o_distance_a_mm) && $stable(o_distance_b_mm)
            && $stable(o_distance_c_mm)))
        else $error("stalled result changed");

endmodule

bind multi_ultrasonic_echo_ranger_top muer_check u_muer_check (.*);
